// ===== rtl/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared constants, types and arithmetic helpers of the grid bucket indexer.
// ----------------------------------------------------------------------------
package gbi_pkg;

    localparam int AXES_MAX    = 8;
    localparam int NUM_AXES    = 8;
    localparam int POS_BITS    = 48;
    localparam int AXIS_BITS   = 16;
    localparam int BUCKET_EDGE = 20;

    localparam int LEN_W      = 16;
    localparam int DATA_W     = 32;
    localparam int AXIS_IDX_W = $clog2(AXES_MAX);
    localparam int PADDR_W    = AXIS_IDX_W + 2;

    // Strides may reach 2^POS_BITS, one bit past the position range.
    localparam int STR_W = POS_BITS + 1;
    localparam logic [STR_W-1:0]     POS_CAP    = STR_W'(1) << POS_BITS;
    localparam logic [POS_BITS-1:0]  POS_MASK   = '1;
    localparam logic [AXIS_BITS-1:0] AXIS_MAX_V = '1;

    // Division by the bucket edge: multiply by a rounded-up reciprocal.
    localparam int DIV_N  = ((AXIS_BITS > 12) ? AXIS_BITS : 12) + 1;
    localparam int DIV_SH = DIV_N + 13;
    localparam int DIV_MW = DIV_SH + 1;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_SH) + BUCKET_EDGE - 1) / BUCKET_EDGE;
    localparam logic [DIV_MW-1:0] DIV_MV = DIV_MW'(DIV_M);

    // Two quotient bits per division stage.
    localparam int TOP_ST     = (POS_BITS + 1) / 2;
    localparam int AX_ST      = (AXIS_BITS + 1) / 2;
    localparam int DIV_STAGES = TOP_ST + (NUM_AXES - 1) * AX_ST;

    typedef enum logic {
        ST_IDLE,
        ST_BUILD
    } gbi_state_t;

    typedef struct packed {
        logic                                busy;
        logic [AXES_MAX-1:0][STR_W-1:0]      pos_stride;
        logic [AXES_MAX-1:0][STR_W-1:0]      bkt_stride;
        logic [AXES_MAX-1:0]                 edge_one;
        logic [AXES_MAX-1:0][AXIS_BITS-1:0]  eff_len;
    } gbi_cfg_t;

    typedef struct packed {
        logic                                op;
        logic                                oor;
        logic [POS_BITS-1:0]                 rem;
        logic [POS_BITS-1:0]                 dsh;
        logic [POS_BITS-1:0]                 quo;
        logic [AXES_MAX-1:0][AXIS_BITS-1:0]  crd;
    } gbi_div_t;

    typedef struct packed {
        logic                                oor;
        logic [AXES_MAX-1:0][AXIS_BITS-1:0]  crd;
    } gbi_tail_t;

    function automatic logic [DIV_N-1:0] div_edge(input logic [DIV_N-1:0] x);
        logic [DIV_N+DIV_MW-1:0] p;
        p = (DIV_N + DIV_MW)'(x) * (DIV_N + DIV_MW)'(DIV_MV);
        return DIV_N'(p >> DIV_SH);
    endfunction

    // One restoring step: returns {quotient bit, new partial remainder}.
    function automatic logic [POS_BITS:0] div_step(input logic [POS_BITS-1:0] rem,
                                                   input logic din,
                                                   input logic [STR_W-1:0] stride);
        logic [STR_W-1:0] t;
        t = {rem, din};
        if (t >= stride) begin
            return {1'b1, POS_BITS'(t - stride)};
        end
        return {1'b0, POS_BITS'(t)};
    endfunction

endpackage

// ===== rtl/gbi_cfg.sv =====
// ----------------------------------------------------------------------------
// gbi_cfg
// Axis length registers on the APB port and the stride table rebuild.
// ----------------------------------------------------------------------------
module gbi_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbi_pkg::PADDR_W-1:0]   paddr,
    input  logic [gbi_pkg::DATA_W-1:0]    pwdata,
    output logic [gbi_pkg::DATA_W-1:0]    prdata,
    output gbi_pkg::gbi_cfg_t             cfg
);

    localparam int PW = gbi_pkg::STR_W + gbi_pkg::AXIS_BITS;

    logic [gbi_pkg::LEN_W-1:0]     len_reg        [gbi_pkg::AXES_MAX];
    logic [gbi_pkg::AXIS_BITS-1:0] nb_reg         [gbi_pkg::AXES_MAX];
    logic [gbi_pkg::STR_W-1:0]     pos_stride_reg [gbi_pkg::AXES_MAX];
    logic [gbi_pkg::STR_W-1:0]     bkt_stride_reg [gbi_pkg::AXES_MAX];
    gbi_pkg::gbi_state_t           state_reg, state_next;
    logic [gbi_pkg::AXIS_IDX_W-1:0] idx_reg, idx_next, idx_prev;

    logic                            wr;
    logic [gbi_pkg::AXIS_IDX_W-1:0]  widx;
    logic [gbi_pkg::AXIS_BITS-1:0]   eff      [gbi_pkg::AXES_MAX];
    logic [gbi_pkg::AXIS_BITS-1:0]   weff;
    logic [gbi_pkg::AXIS_BITS-1:0]   wnb;
    logic [gbi_pkg::DIV_N-1:0]       wq;
    logic [PW-1:0]                   pos_prod, bkt_prod;
    logic [gbi_pkg::STR_W-1:0]       pos_sat, bkt_sat;

    assign wr       = psel & penable & pwrite;
    assign widx     = paddr[gbi_pkg::PADDR_W-1:2];
    assign idx_prev = idx_reg - gbi_pkg::AXIS_IDX_W'(1);
    assign prdata   = gbi_pkg::DATA_W'(len_reg[widx]);

    // Zero length and absent axes act as length 1.
    always_comb begin
        for (int i = 0; i < gbi_pkg::AXES_MAX; i++) begin
            if (i >= gbi_pkg::NUM_AXES || len_reg[i][gbi_pkg::AXIS_BITS-1:0] == '0) begin
                eff[i] = gbi_pkg::AXIS_BITS'(1);
            end else begin
                eff[i] = len_reg[i][gbi_pkg::AXIS_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (32'(widx) >= gbi_pkg::NUM_AXES || pwdata[gbi_pkg::AXIS_BITS-1:0] == '0) begin
            weff = gbi_pkg::AXIS_BITS'(1);
        end else begin
            weff = pwdata[gbi_pkg::AXIS_BITS-1:0];
        end
        wq = gbi_pkg::div_edge(gbi_pkg::DIV_N'(weff) + gbi_pkg::DIV_N'(gbi_pkg::BUCKET_EDGE - 1));
        wnb = (weff == gbi_pkg::AXIS_BITS'(1)) ? gbi_pkg::AXIS_BITS'(1)
                                                : gbi_pkg::AXIS_BITS'(wq);
    end

    // Running products, capped one past the position range.
    always_comb begin
        pos_prod = PW'(pos_stride_reg[idx_prev]) * PW'(eff[idx_prev]);
        bkt_prod = PW'(bkt_stride_reg[idx_prev]) * PW'(nb_reg[idx_prev]);
        pos_sat  = (pos_prod > PW'(gbi_pkg::POS_CAP)) ? gbi_pkg::POS_CAP
                                                      : gbi_pkg::STR_W'(pos_prod);
        bkt_sat  = (bkt_prod > PW'(gbi_pkg::POS_CAP)) ? gbi_pkg::POS_CAP
                                                      : gbi_pkg::STR_W'(bkt_prod);
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            gbi_pkg::ST_IDLE: begin
                idx_next = idx_reg;
            end
            gbi_pkg::ST_BUILD: begin
                idx_next = idx_reg + gbi_pkg::AXIS_IDX_W'(1);
                if (idx_reg == gbi_pkg::AXIS_IDX_W'(gbi_pkg::AXES_MAX - 1)) begin
                    state_next = gbi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gbi_pkg::ST_IDLE;
            end
        endcase
        // A new length restarts the rebuild from axis 1.
        if (wr) begin
            state_next = gbi_pkg::ST_BUILD;
            idx_next   = gbi_pkg::AXIS_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbi_pkg::ST_IDLE;
            idx_reg   <= '0;
            for (int i = 0; i < gbi_pkg::AXES_MAX; i++) begin
                len_reg[i]        <= gbi_pkg::LEN_W'(1);
                nb_reg[i]         <= gbi_pkg::AXIS_BITS'(1);
                pos_stride_reg[i] <= gbi_pkg::STR_W'(1);
                bkt_stride_reg[i] <= gbi_pkg::STR_W'(1);
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (wr) begin
                len_reg[widx] <= pwdata[gbi_pkg::LEN_W-1:0];
                nb_reg[widx]  <= wnb;
            end
            if (state_reg == gbi_pkg::ST_BUILD) begin
                pos_stride_reg[idx_reg] <= pos_sat;
                bkt_stride_reg[idx_reg] <= bkt_sat;
            end
        end
    end

    always_comb begin
        cfg.busy = (state_reg == gbi_pkg::ST_BUILD);
        for (int i = 0; i < gbi_pkg::AXES_MAX; i++) begin
            cfg.pos_stride[i] = pos_stride_reg[i];
            cfg.bkt_stride[i] = bkt_stride_reg[i];
            cfg.eff_len[i]    = eff[i];
            cfg.edge_one[i]   = (eff[i] == gbi_pkg::AXIS_BITS'(1));
        end
    end

endmodule

// ===== rtl/gbi_split.sv =====
// ----------------------------------------------------------------------------
// gbi_split
// Mixed-radix split of a linear position: restoring division pipeline,
// top axis first, two quotient bits per stage.
// ----------------------------------------------------------------------------
module gbi_split (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  gbi_pkg::gbi_div_t  in_data,
    input  gbi_pkg::gbi_cfg_t  cfg,
    output logic               out_vld,
    output gbi_pkg::gbi_div_t  out_data
);

    gbi_pkg::gbi_div_t               st_q  [gbi_pkg::DIV_STAGES];
    logic [gbi_pkg::DIV_STAGES-1:0]  vld_q;

    for (genvar a = 0; a < gbi_pkg::NUM_AXES; a++) begin : g_ax
        localparam int AX  = gbi_pkg::NUM_AXES - 1 - a;
        localparam int N   = (a == 0) ? gbi_pkg::POS_BITS : gbi_pkg::AXIS_BITS;
        localparam int NS  = (N + 1) / 2;
        localparam int OFF = (a == 0) ? 0 : gbi_pkg::TOP_ST + (a - 1) * gbi_pkg::AX_ST;

        for (genvar k = 0; k < NS; k++) begin : g_st
            localparam int S = OFF + k;

            gbi_pkg::gbi_div_t d_in, d_next, stage_reg;
            logic              v_in, stage_vld_reg;

            if (S == 0) begin : g_head
                assign d_in = in_data;
                assign v_in = in_vld;
            end else begin : g_chain
                assign d_in = st_q[S-1];
                assign v_in = vld_q[S-1];
            end

            always_comb begin
                logic [gbi_pkg::POS_BITS:0] sr;
                d_next = d_in;
                sr     = '0;
                // Axis entry: the carried remainder becomes the dividend.
                if (k == 0) begin
                    d_next.rem = d_in.rem >> N;
                    d_next.dsh = d_in.rem << (gbi_pkg::POS_BITS - N);
                    d_next.quo = '0;
                end
                for (int j = 0; j < 2; j++) begin
                    if (2 * k + j < N) begin
                        sr = gbi_pkg::div_step(d_next.rem, d_next.dsh[gbi_pkg::POS_BITS-1],
                                               cfg.pos_stride[AX]);
                        d_next.rem = sr[gbi_pkg::POS_BITS-1:0];
                        d_next.quo = {d_next.quo[gbi_pkg::POS_BITS-2:0],
                                      sr[gbi_pkg::POS_BITS]};
                        d_next.dsh = d_next.dsh << 1;
                    end
                end
                if (k == NS - 1 && !d_in.op) begin
                    if (a == 0) begin
                        // Top axis: flag and saturate a quotient past the grid.
                        if (d_next.quo >= gbi_pkg::POS_BITS'(cfg.eff_len[AX])) begin
                            d_next.oor = 1'b1;
                        end
                        if (d_next.quo > gbi_pkg::POS_BITS'(gbi_pkg::AXIS_MAX_V)) begin
                            d_next.crd[AX] = gbi_pkg::AXIS_MAX_V;
                        end else begin
                            d_next.crd[AX] = d_next.quo[gbi_pkg::AXIS_BITS-1:0];
                        end
                    end else begin
                        d_next.crd[AX] = d_next.quo[gbi_pkg::AXIS_BITS-1:0];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_vld_reg <= 1'b0;
                end else if (en) begin
                    stage_vld_reg <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    stage_reg <= d_next;
                end
            end

            assign st_q[S]  = stage_reg;
            assign vld_q[S] = stage_vld_reg;
        end
    end

    assign out_data = st_q[gbi_pkg::DIV_STAGES-1];
    assign out_vld  = vld_q[gbi_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/grid_bucket_index_top.sv =====
// ----------------------------------------------------------------------------
// grid_bucket_index_top
// Eight-axis grid indexer: splits a linear position into coordinates or
// takes coordinates, and returns the coarse bucket number.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | opcode, position, coord_in_0..7
//  m_      | out       | m_valid / m_ready    | bucket, coord_0..7, out_of_range
//  apb     | in/out    | psel/penable/pready  | axis_len_0..7 at 4*i
//
//  One beat enters per cycle while s_ready is high. A beat passes the input
//  register, the division chain at two quotient bits a stage, stages b1 to b4
//  and the output register. A length write rebuilds the stride tables, with
//  s_ready low meanwhile. Reset is synchronous, active low.
//  A stalled result stalls the whole pipeline together; nothing is lost.
// ----------------------------------------------------------------------------
module grid_bucket_index_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [gbi_pkg::POS_BITS-1:0]    s_position,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_0,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_1,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_2,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_3,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_4,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_5,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_6,
    input  logic [gbi_pkg::AXIS_BITS-1:0]   s_coord_in_7,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gbi_pkg::POS_BITS-1:0]    m_bucket,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_0,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_1,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_2,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_3,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_4,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_5,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_6,
    output logic [gbi_pkg::AXIS_BITS-1:0]   m_coord_7,
    output logic                            m_out_of_range,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbi_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbi_pkg::DATA_W-1:0]      pwdata,
    output logic [gbi_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int AX = gbi_pkg::AXES_MAX;
    localparam int PW = gbi_pkg::AXIS_BITS + gbi_pkg::STR_W;
    localparam int SW = gbi_pkg::POS_BITS + 1;

    gbi_pkg::gbi_cfg_t  cfg;
    logic               en;

    logic               in_vld_reg;
    gbi_pkg::gbi_div_t  in_reg, in_next;
    logic [gbi_pkg::AXIS_BITS-1:0] cin [AX];

    logic               sp_vld;
    gbi_pkg::gbi_div_t  sp_data;

    logic                               b1_vld_reg;
    logic [AX-1:0][gbi_pkg::AXIS_BITS-1:0] b1_qb_reg, b1_qb_next;
    gbi_pkg::gbi_tail_t                 b1_tail_reg;

    logic                               b2_vld_reg;
    logic [AX-1:0][gbi_pkg::POS_BITS-1:0] b2_term_reg, b2_term_next;
    gbi_pkg::gbi_tail_t                 b2_tail_reg;

    logic                               b3_vld_reg;
    logic [AX/2-1:0][gbi_pkg::POS_BITS-1:0] b3_sum_reg, b3_sum_next;
    gbi_pkg::gbi_tail_t                 b3_tail_reg;

    logic                               b4_vld_reg;
    logic [AX/4-1:0][gbi_pkg::POS_BITS-1:0] b4_sum_reg, b4_sum_next;
    gbi_pkg::gbi_tail_t                 b4_tail_reg;

    logic                               out_vld_reg;
    logic [gbi_pkg::POS_BITS-1:0]       out_bucket_reg, out_bucket_next;
    gbi_pkg::gbi_tail_t                 out_tail_reg;

    gbi_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready  = 1'b1;
    // Advance everything unless the output beat is held.
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en && !cfg.busy;

    assign cin[0] = s_coord_in_0;
    assign cin[1] = s_coord_in_1;
    assign cin[2] = s_coord_in_2;
    assign cin[3] = s_coord_in_3;
    assign cin[4] = s_coord_in_4;
    assign cin[5] = s_coord_in_5;
    assign cin[6] = s_coord_in_6;
    assign cin[7] = s_coord_in_7;

    always_comb begin
        in_next.op  = s_opcode;
        in_next.oor = 1'b0;
        in_next.rem = s_position;
        in_next.dsh = '0;
        in_next.quo = '0;
        for (int i = 0; i < AX; i++) begin
            in_next.crd[i] = '0;
            if (s_opcode && i < gbi_pkg::NUM_AXES) begin
                in_next.crd[i] = cin[i];
                if (cin[i] >= cfg.eff_len[i]) begin
                    in_next.oor = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid && !cfg.busy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= in_next;
        end
    end

    gbi_split u_split (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (in_vld_reg),
        .in_data  (in_reg),
        .cfg      (cfg),
        .out_vld  (sp_vld),
        .out_data (sp_data)
    );

    // Bucket coordinate per axis.
    always_comb begin
        for (int i = 0; i < AX; i++) begin
            if (cfg.edge_one[i]) begin
                b1_qb_next[i] = sp_data.crd[i];
            end else begin
                b1_qb_next[i] = gbi_pkg::AXIS_BITS'(
                    gbi_pkg::div_edge(gbi_pkg::DIV_N'(sp_data.crd[i])));
            end
        end
    end

    // Weighted terms, saturated to the position range.
    always_comb begin
        logic [PW-1:0] prod;
        prod = '0;
        for (int i = 0; i < AX; i++) begin
            prod = PW'(b1_qb_reg[i]) * PW'(cfg.bkt_stride[i]);
            b2_term_next[i] = (prod > PW'(gbi_pkg::POS_MASK)) ? gbi_pkg::POS_MASK
                                                               : gbi_pkg::POS_BITS'(prod);
        end
    end

    always_comb begin
        logic [SW-1:0] s3, s4, s5;
        s3 = '0;
        s4 = '0;
        for (int i = 0; i < AX / 2; i++) begin
            s3 = SW'(b2_term_reg[2*i]) + SW'(b2_term_reg[2*i+1]);
            b3_sum_next[i] = s3[gbi_pkg::POS_BITS] ? gbi_pkg::POS_MASK
                                                   : s3[gbi_pkg::POS_BITS-1:0];
        end
        for (int i = 0; i < AX / 4; i++) begin
            s4 = SW'(b3_sum_reg[2*i]) + SW'(b3_sum_reg[2*i+1]);
            b4_sum_next[i] = s4[gbi_pkg::POS_BITS] ? gbi_pkg::POS_MASK
                                                   : s4[gbi_pkg::POS_BITS-1:0];
        end
        s5 = SW'(b4_sum_reg[0]) + SW'(b4_sum_reg[1]);
        out_bucket_next = s5[gbi_pkg::POS_BITS] ? gbi_pkg::POS_MASK
                                                : s5[gbi_pkg::POS_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            b3_vld_reg  <= 1'b0;
            b4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg  <= sp_vld;
            b2_vld_reg  <= b1_vld_reg;
            b3_vld_reg  <= b2_vld_reg;
            b4_vld_reg  <= b3_vld_reg;
            out_vld_reg <= b4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_qb_reg       <= b1_qb_next;
            b1_tail_reg.oor <= sp_data.oor;
            b1_tail_reg.crd <= sp_data.crd;
            b2_term_reg     <= b2_term_next;
            b2_tail_reg     <= b1_tail_reg;
            b3_sum_reg      <= b3_sum_next;
            b3_tail_reg     <= b2_tail_reg;
            b4_sum_reg      <= b4_sum_next;
            b4_tail_reg     <= b3_tail_reg;
            out_bucket_reg  <= out_bucket_next;
            out_tail_reg    <= b4_tail_reg;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_bucket       = out_bucket_reg;
    assign m_coord_0      = out_tail_reg.crd[0];
    assign m_coord_1      = out_tail_reg.crd[1];
    assign m_coord_2      = out_tail_reg.crd[2];
    assign m_coord_3      = out_tail_reg.crd[3];
    assign m_coord_4      = out_tail_reg.crd[4];
    assign m_coord_5      = out_tail_reg.crd[5];
    assign m_coord_6      = out_tail_reg.crd[6];
    assign m_coord_7      = out_tail_reg.crd[7];
    assign m_out_of_range = out_tail_reg.oor;

    a_write_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite) |=> !s_ready)
        else $error("input open right after a length write");

    a_stall_reaches_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input open while the output beat is held");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(b4_vld_reg) && $stable(b4_sum_reg)))
        else $error("pipeline moved during an output stall");

endmodule

// ===== tb/sv/grid_bucket_index_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_bucket_index_top_test
// Drives position splits and coordinate lookups through the grid bucket
// indexer under several axis length settings, with random gaps on both
// channels, and checks every result beat against a local bucket predictor or a directed expected value.
// ----------------------------------------------------------------------------
module grid_bucket_index_top_test;

    localparam int                NAX      = 8;
    localparam longint unsigned   GRID_CAP = 64'd1 << gbi_pkg::POS_BITS;
    localparam longint unsigned   SUM_MAX  = GRID_CAP - 1;
    localparam logic              OP_SPLIT  = 1'b0;
    localparam logic              OP_LOOKUP = 1'b1;

    typedef struct {
        logic                 op;
        logic [47:0]          pos;
        logic [15:0]          c[NAX];
    } lookup_t;

    typedef struct {
        logic [47:0]          bucket;
        logic [15:0]          c[NAX];
        logic                 oor;
    } bucket_res_t;

    typedef struct {
        lookup_t              req;
        logic                 typed;
        bucket_res_t          res;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready, s_opcode = 1'b0;
    logic [47:0] s_position = '0;
    logic [15:0] s_ci[NAX];
    logic m_valid, m_ready = 1'b0, m_out_of_range;
    logic [47:0] m_bucket;
    logic [15:0] m_c[NAX];
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
    logic [gbi_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;

    logic [15:0]     axis_len_q[NAX];
    longint unsigned pos_stride_q[NAX];
    longint unsigned bkt_stride_q[NAX];
    longint unsigned edge_q[NAX];
    bucket_res_t     bucket_queue[$];
    int              fail_cnt = 0;
    logic            quiet_sink = 1'b0;

    initial for (int i = 0; i < NAX; i++) s_ci[i] = '0;

    grid_bucket_index_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_position(s_position),
        .s_coord_in_0(s_ci[0]), .s_coord_in_1(s_ci[1]), .s_coord_in_2(s_ci[2]),
        .s_coord_in_3(s_ci[3]), .s_coord_in_4(s_ci[4]), .s_coord_in_5(s_ci[5]),
        .s_coord_in_6(s_ci[6]), .s_coord_in_7(s_ci[7]),
        .m_valid(m_valid), .m_ready(m_ready), .m_bucket(m_bucket),
        .m_coord_0(m_c[0]), .m_coord_1(m_c[1]), .m_coord_2(m_c[2]),
        .m_coord_3(m_c[3]), .m_coord_4(m_c[4]), .m_coord_5(m_c[5]),
        .m_coord_6(m_c[6]), .m_coord_7(m_c[7]),
        .m_out_of_range(m_out_of_range),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("grid_bucket_index_top: mismatch");
        $finish;
    end

    function automatic longint unsigned cap_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned cap);
        if (a != 0 && b > cap / a) return cap;
        return (a * b > cap) ? cap : a * b;
    endfunction

    function automatic longint unsigned len_of(int i);
        return (axis_len_q[i] == 0) ? 64'd1 : 64'(axis_len_q[i]);
    endfunction

    function automatic void rebuild_strides();
        longint unsigned plen, pnb, len, nb;
        plen = 1;
        pnb = 1;
        for (int i = 0; i < NAX; i++) begin
            len = len_of(i);
            edge_q[i] = (len == 1) ? 64'd1 : 64'(gbi_pkg::BUCKET_EDGE);
            nb = (len + edge_q[i] - 1) / edge_q[i];
            pos_stride_q[i] = (i == 0) ? 64'd1 : cap_mul(pos_stride_q[i-1], plen, GRID_CAP);
            bkt_stride_q[i] = (i == 0) ? 64'd1 : cap_mul(bkt_stride_q[i-1], pnb, GRID_CAP);
            plen = len;
            pnb = nb;
        end
    endfunction

    function automatic bucket_res_t grid_lookup(lookup_t r);
        bucket_res_t     o;
        longint unsigned p, q, sum, term;
        o.oor = 1'b0;
        if (r.op == OP_SPLIT) begin
            p = 64'(r.pos);
            for (int i = NAX - 1; i >= 0; i--) begin
                q = p / pos_stride_q[i];
                p -= q * pos_stride_q[i];
                if (i == NAX - 1) begin
                    if (q >= len_of(i)) o.oor = 1'b1;
                    if (q > 65535) q = 65535;
                end
                o.c[i] = q[15:0];
            end
        end else begin
            for (int i = 0; i < NAX; i++) begin
                o.c[i] = r.c[i];
                if (64'(r.c[i]) >= len_of(i)) o.oor = 1'b1;
            end
        end
        sum = 0;
        for (int i = NAX - 1; i >= 0; i--) begin
            term = cap_mul(64'(o.c[i]) / edge_q[i], bkt_stride_q[i], SUM_MAX);
            sum = (term > SUM_MAX - sum) ? SUM_MAX : sum + term;
        end
        o.bucket = sum[47:0];
        return o;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stall on m_ready, checked at the rising edge
    always @(negedge aclk) begin
        m_ready <= quiet_sink ? 1'b1 : ($urandom_range(0, 99) < 65);
    end

    always @(posedge aclk) begin
        bucket_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (bucket_queue.size() == 0) begin
                $display("%0t: unexpected result beat bucket=%h", $time, m_bucket);
                fail_cnt++;
            end else begin
                e = bucket_queue.pop_front();
                if (m_bucket !== e.bucket) begin
                    $display("%0t: bucket exp %h got %h", $time, e.bucket, m_bucket);
                    fail_cnt++;
                end
                for (int i = 0; i < NAX; i++)
                    if (m_c[i] !== e.c[i]) begin
                        $display("%0t: coord_%0d exp %h got %h", $time, i, e.c[i], m_c[i]);
                        fail_cnt++;
                    end
                if (m_out_of_range !== e.oor) begin
                    $display("%0t: out_of_range exp %b got %b", $time, e.oor,
                             m_out_of_range);
                    fail_cnt++;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_lookup(lookup_t r, logic typed, bucket_res_t exp_res, int gap);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode = r.op;
        s_position = r.pos;
        for (int i = 0; i < NAX; i++) s_ci[i] = r.c[i];
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed) begin
            bucket_queue.insert(bucket_queue.size(), exp_res);
        end else begin
            bucket_queue.insert(bucket_queue.size(), grid_lookup(r));
        end
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (bucket_queue.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_len(int idx, logic [15:0] v);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = gbi_pkg::PADDR_W'(4 * idx);
        pwdata = {16'($urandom), v};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        axis_len_q[idx] = v;
        rebuild_strides();
    endtask

    function automatic lookup_t rand_lookup();
        lookup_t         r;
        longint unsigned grid, p;
        int              k;
        k = $urandom_range(0, 99);
        r.op = 1'($urandom_range(0, 1));
        r.pos = 48'({$urandom, $urandom});
        for (int i = 0; i < NAX; i++) r.c[i] = 16'($urandom);
        grid = cap_mul(pos_stride_q[NAX-1], len_of(NAX-1), GRID_CAP);
        if (r.op == OP_SPLIT) begin
            p = {$urandom, $urandom};
            if (k < 70) r.pos = 48'(p % grid);
            else if (k < 85 && grid < GRID_CAP) r.pos = 48'(grid + $urandom_range(0, 3));
        end else if (k < 85) begin
            for (int i = 0; i < NAX; i++)
                r.c[i] = 16'($urandom_range(0, int'(len_of(i)) - 1));
            if (k >= 70) r.c[$urandom_range(0, NAX-1)] = 16'(len_of(NAX-1));
        end
        return r;
    endfunction

    initial begin
        dir_row_t    dir_tbl[$];
        dir_row_t    row;
        lookup_t     r;
        logic [15:0] v;
        int          no_idle;

        for (int i = 0; i < NAX; i++) axis_len_q[i] = 16'd1;
        rebuild_strides();

        // directed rows after reset: every axis has length 1
        row.typed = 1'b1;
        row.req.op = OP_SPLIT;
        row.req.c = '{default: 16'h0};
        row.req.pos = 48'd0;
        row.res.bucket = 48'd0; row.res.c = '{default: 16'h0}; row.res.oor = 1'b0;
        dir_tbl.insert(dir_tbl.size(), row);
        row.req.pos = 48'd1;
        row.res.bucket = 48'd1; row.res.c[7] = 16'd1; row.res.oor = 1'b1;
        dir_tbl.insert(dir_tbl.size(), row);
        row.req.pos = '1;
        row.res.bucket = 48'd65535; row.res.c[7] = 16'hFFFF;
        dir_tbl.insert(dir_tbl.size(), row);
        row.req.op = OP_LOOKUP;
        row.req.pos = '1;
        row.res.bucket = 48'd0; row.res.c = '{default: 16'h0}; row.res.oor = 1'b0;
        dir_tbl.insert(dir_tbl.size(), row);
        row.req.c = '{default: 16'hFFFF};
        row.req.pos = '0;
        row.res.bucket = 48'd524280; row.res.c = '{default: 16'hFFFF}; row.res.oor = 1'b1;
        dir_tbl.insert(dir_tbl.size(), row);
        row.req.c = '{default: 16'h0}; row.req.c[3] = 16'd1;
        row.res.bucket = 48'd1; row.res.c = '{default: 16'h0}; row.res.c[3] = 16'd1;
        dir_tbl.insert(dir_tbl.size(), row);
        row.typed = 1'b0;
        for (int i = 0; i < 6; i++) begin
            row.req.op = i[0];
            row.req.pos = 48'h5555_5555_5555 << i;
            row.req.c = '{default: 16'hAAAA >> i};
            dir_tbl.insert(dir_tbl.size(), row);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        foreach (dir_tbl[n])
            send_lookup(dir_tbl[n].req, dir_tbl[n].typed, dir_tbl[n].res, gap_len());

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            for (int i = 0; i < NAX; i++) begin
                case (ph)
                    0:       v = 16'($urandom_range(1, 45));
                    1:       v = 16'hFFFF;
                    2:       v = (i % 3 == 0) ? 16'd0 : ((i % 3 == 1) ? 16'd20 : 16'd21);
                    3:       v = (i == NAX - 1) ? 16'hFFFF : 16'd1;
                    4:       v = 16'($urandom);
                    5:       v = 16'($urandom_range(1, 300));
                    6:       v = (i < 2) ? 16'hFFFF : 16'($urandom_range(1, 8));
                    default: v = 16'($urandom_range(2, 40));
                endcase
                write_len(i, v);
            end
            // drop the stall on the result side for part of some phases
            no_idle = $urandom_range(0, 1);
            for (int n = 0; n < 142; n++) begin
                quiet_sink = (no_idle != 0) && (n < 40);
                r = rand_lookup();
                send_lookup(r, 1'b0, row.res, quiet_sink ? 0 : gap_len());
            end
            quiet_sink = 1'b0;
        end

        drain();
        if (fail_cnt == 0) begin
            $display("grid_bucket_index_top: match");
        end else begin
            $display("grid_bucket_index_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gbi_pkg.sv
rtl/gbi_cfg.sv
rtl/gbi_split.sv
rtl/grid_bucket_index_top.sv
tb/sv/grid_bucket_index_top_test.sv
